### hdl/lstpc_pkg.sv
// ----------------------------------------------------------------------------
// lstpc_pkg: shared types and constants for the lidar point transform
// Register indexes, inverse CORDIC gain and arctangent table, beat type of the
// queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none
package lstpc_pkg;

  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned CfgIdxW        = 3;
  localparam int unsigned CfgDataW       = 64;
  localparam int unsigned RangeW         = 20;
  localparam int unsigned AngleW         = 32;
  localparam int unsigned CoordW         = 31;
  localparam int unsigned QueueDepth     = 2;

  typedef enum logic [CfgIdxW-1:0] {
    RegMinRange  = 3'd0,
    RegMaxRange  = 3'd1,
    RegErrLimit  = 3'd2,
    RegStart     = 3'd3,
    RegStep      = 3'd4,
    RegRowX      = 3'd5,
    RegRowY      = 3'd6,
    RegRowZ      = 3'd7
  } cfg_reg_e;

  // Inverse CORDIC gain in Q30
  localparam logic [29:0] GainQ30 = 30'd652032874;

  // Beat handed from front to back
  typedef struct packed {
    logic                valid;
    logic                last;
    logic [RangeW-1:0]   range;
    logic [AngleW-1:0]   angle;
  } beam_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### hdl/lstpc_front.sv
// ----------------------------------------------------------------------------
// lstpc_front: beam intake and classification
// Checks range limits, forms the beam angle and advances the scan offset.
// ----------------------------------------------------------------------------
`default_nettype none
module lstpc_front
  import lstpc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [RangeW-1:0] range_i,
  input  wire logic              last_i,
  input  wire logic [RangeW-1:0] min_i,
  input  wire logic [RangeW-1:0] max_i,
  input  wire logic [RangeW-1:0] lim_i,
  input  wire logic [AngleW-1:0] start_i,
  input  wire logic [AngleW-1:0] step_i,
  output beam_t                  beam_o
);

  logic [AngleW-1:0] offset_q, offset_d;

  // classify the beat
  always_comb begin
    beam_o.valid = (range_i >= min_i) && (range_i <= max_i) && (range_i >= lim_i);
    beam_o.last  = last_i;
    beam_o.range = range_i;
    beam_o.angle = start_i + offset_q;
    offset_d     = last_i ? '0 : offset_q + step_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
    end else if (push_i) begin
      offset_q <= offset_d;
    end
  end

endmodule
`default_nettype wire

### hdl/lstpc_queue.sv
// ----------------------------------------------------------------------------
// lstpc_queue: small FIFO between front and back
// Register-based, depth from parameter.
// ----------------------------------------------------------------------------
`default_nettype none
module lstpc_queue
  import lstpc_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  wr_i,
  input  wire beam_t wdata_i,
  output logic       full_o,
  input  wire logic  rd_i,
  output beam_t      rdata_o,
  output logic       empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  beam_t             mem_q [Depth];
  logic [PtrW-1:0]   wp_q, rp_q;
  logic [PtrW:0]     cnt_q;

  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i && !full_o) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i && !full_o)
        wp_q <= (wp_q == PtrW'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (rd_i && !empty_o)
        rp_q <= (rp_q == PtrW'(Depth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(wr_i && !full_o) - (PtrW+1)'(rd_i && !empty_o);
    end
  end

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(Depth)) else $error("queue count overflow");
  a_no_wr_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o && wr_i && !rd_i) |=> full_o) else $error("full lost");
  a_empty_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty_o && !wr_i) |=> empty_o) else $error("empty lost");
`endif

endmodule
`default_nettype wire

### hdl/lstpc_back.sv
// ----------------------------------------------------------------------------
// lstpc_back: CORDIC rotation and affine transform
// Sequencer: gain multiply, iterative CORDIC, six products on one shared
// multiplier, rounding and saturation into an output register.
// ----------------------------------------------------------------------------
`default_nettype none
module lstpc_back
  import lstpc_pkg::*;
#(
  parameter int unsigned CordicSteps = CordicStepsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              empty_i,
  input  wire beam_t             beam_i,
  output logic                   take_o,
  input  wire logic [63:0]       row_x_i,
  input  wire logic [63:0]       row_y_i,
  input  wire logic [63:0]       row_z_i,
  output logic                   empty_o,
  input  wire logic              pop_i,
  output logic                   point_valid_o,
  output logic signed [CoordW-1:0] x_o,
  output logic signed [CoordW-1:0] y_o,
  output logic signed [CoordW-1:0] z_o,
  output logic                   end_of_scan_o
);

  typedef enum logic [2:0] {
    StIdle, StGain, StRot, StMul, StOut
  } state_e;

  localparam int unsigned CntW = $clog2(CordicSteps + 1);

  state_e                 state_q;
  logic [CntW-1:0]        it_q;
  logic [2:0]             mi_q;
  logic signed [39:0]     x_q, y_q;
  logic signed [32:0]     z_q;
  logic [1:0]             quad_q;
  logic                   last_q, valid_q;
  logic [RangeW-1:0]      range_q;
  logic signed [66:0]     acc_q;
  logic signed [CoordW-1:0] res_q [3];
  logic                   full_q, full_d;

  // rotated point: px = -s, py = c
  logic signed [39:0] px, py;
  always_comb begin
    case (quad_q)
      2'd0:    begin px = -y_q; py =  x_q; end
      2'd1:    begin px = -x_q; py = -y_q; end
      2'd2:    begin px =  y_q; py = -x_q; end
      default: begin px =  x_q; py =  y_q; end
    endcase
  end

  // coefficient and operand for the shared multiply
  logic [63:0]         row;
  logic signed [17:0]  coef;
  logic signed [39:0]  opnd;
  logic signed [57:0]  prod;
  always_comb begin
    case (mi_q[2:1])
      2'd0:    row = row_x_i;
      2'd1:    row = row_y_i;
      default: row = row_z_i;
    endcase
    coef = mi_q[0] ? $signed(row[45:28]) : $signed(row[63:46]);
    opnd = mi_q[0] ? py : px;
    prod = coef * opnd;
  end

  // round and saturate the finished row
  logic signed [66:0] sum, shd;
  logic signed [CoordW-1:0] sat;
  always_comb begin
    sum = acc_q + 67'(prod) + 67'sd536870912;
    shd = sum >>> 30;
    if (shd > 67'sd1073741823)       sat = 31'sh3FFFFFFF;
    else if (shd < -67'sd1073741824) sat = 31'sh40000000;
    else                             sat = shd[CoordW-1:0];
  end

  logic signed [39:0] dx, dy;
  logic signed [32:0] at;
  assign dx = y_q >>> it_q;
  assign dy = x_q >>> it_q;
  assign at = $signed({1'b0, atan_lut(5'(it_q))});

  logic [51:0] gp;
  assign gp = range_q * GainQ30;

  logic [AngleW-1:0] ap;
  assign ap = beam_i.angle + 32'h2000_0000;

  assign take_o  = (state_q == StIdle) && !empty_i;
  assign empty_o = !full_q;

  // output register occupancy: freed by a pop, refilled from StOut
  always_comb begin
    full_d = full_q;
    if (pop_i && full_q) full_d = 1'b0;
    if (state_q == StOut && (!full_q || pop_i)) full_d = 1'b1;
  end

  // sequencer with output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      full_q  <= 1'b0;
      it_q    <= '0;
      mi_q    <= '0;
    end else begin
      full_q <= full_d;
      case (state_q)
        StIdle: if (!empty_i) begin
          range_q <= beam_i.range;
          last_q  <= beam_i.last;
          valid_q <= beam_i.valid;
          quad_q  <= ap[31:30];
          z_q     <= $signed({3'b0, ap[29:0]}) - 33'sd536870912;
          state_q <= StGain;
        end
        StGain: begin
          x_q     <= $signed({2'b0, gp[51:14]});
          y_q     <= '0;
          it_q    <= '0;
          state_q <= StRot;
        end
        StRot: begin
          if (it_q == CntW'(CordicSteps)) begin
            mi_q    <= '0;
            acc_q   <= '0;
            state_q <= StMul;
          end else begin
            if (!z_q[32]) begin
              x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - at;
            end else begin
              x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + at;
            end
            it_q <= it_q + 1'b1;
          end
        end
        StMul: begin
          if (!mi_q[0]) begin
            acc_q <= 67'(prod) + {{7{row[27]}}, row[27:0], 32'b0};
          end else begin
            res_q[mi_q[2:1]] <= valid_q ? sat : '0;
            acc_q <= '0;
          end
          if (mi_q == 3'd5) state_q <= StOut;
          mi_q <= mi_q + 1'b1;
        end
        StOut: if (!full_q || pop_i) begin
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StOut && (!full_q || pop_i)) begin
      point_valid_o <= valid_q;
      end_of_scan_o <= last_q;
      x_o <= res_q[0];
      y_o <= res_q[1];
      z_o <= res_q[2];
    end
  end

`ifndef SYNTH
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o |=> state_q == StGain) else $error("take outside idle");
  a_it_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    it_q <= CntW'(CordicSteps)) else $error("cordic counter overrun");
  a_inv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !point_valid_o) |-> (x_o == '0 && y_o == '0 && z_o == '0))
    else $error("invalid beam carries data");
`endif

endmodule
`default_nettype wire

### hdl/laser_scan_to_point_cloud.sv
// ----------------------------------------------------------------------------
// laser_scan_to_point_cloud: lidar beam to transformed 3-D point
// Front classifies beams, a small queue decouples, back computes points.
// ----------------------------------------------------------------------------
// Each beam runs an iterative CORDIC at one step a cycle, then six row
// products through one shared multiplier. Beams queue while the back part
// works, and a finished point waits in the output register. Configure only
// while idle.
`default_nettype none
module laser_scan_to_point_cloud
  import lstpc_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = CordicStepsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic [RangeW-1:0]    range_mm_i,
  input  wire logic                 last_beam_i,
  output logic                      empty,
  input  wire logic                 pop,
  output logic                      point_valid_o,
  output logic signed [CoordW-1:0]  x_quarter_mm_o,
  output logic signed [CoordW-1:0]  y_quarter_mm_o,
  output logic signed [CoordW-1:0]  z_quarter_mm_o,
  output logic                      end_of_scan_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i
);

  logic [RangeW-1:0] min_q, max_q, lim_q;
  logic [AngleW-1:0] start_q, step_q;
  logic [63:0]       rowx_q, rowy_q, rowz_q;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q   <= '0;
      max_q   <= '0;
      lim_q   <= 20'd66;
      start_q <= '0;
      step_q  <= '0;
      rowx_q  <= 64'h4000_0000_0000_0000;
      rowy_q  <= 64'h0000_1000_0000_0000;
      rowz_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        RegMinRange: min_q   <= cfg_data_i[RangeW-1:0];
        RegMaxRange: max_q   <= cfg_data_i[RangeW-1:0];
        RegErrLimit: lim_q   <= cfg_data_i[RangeW-1:0];
        RegStart:    start_q <= cfg_data_i[AngleW-1:0];
        RegStep:     step_q  <= cfg_data_i[AngleW-1:0];
        RegRowX:     rowx_q  <= cfg_data_i;
        RegRowY:     rowy_q  <= cfg_data_i;
        RegRowZ:     rowz_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  beam_t fbeam, qbeam;
  logic  qempty, take, acc;

  assign acc = push && !full;

  lstpc_front u_front (
    .clk_i, .rst_ni, .push_i(acc), .range_i(range_mm_i), .last_i(last_beam_i),
    .min_i(min_q), .max_i(max_q), .lim_i(lim_q), .start_i(start_q),
    .step_i(step_q), .beam_o(fbeam)
  );

  lstpc_queue u_queue (
    .clk_i, .rst_ni, .wr_i(push), .wdata_i(fbeam), .full_o(full),
    .rd_i(take), .rdata_o(qbeam), .empty_o(qempty)
  );

  lstpc_back #(.CordicSteps(CORDIC_STEPS)) u_back (
    .clk_i, .rst_ni, .empty_i(qempty), .beam_i(qbeam), .take_o(take),
    .row_x_i(rowx_q), .row_y_i(rowy_q), .row_z_i(rowz_q),
    .empty_o(empty), .pop_i(pop), .point_valid_o,
    .x_o(x_quarter_mm_o), .y_o(y_quarter_mm_o), .z_o(z_quarter_mm_o),
    .end_of_scan_o
  );

endmodule
`default_nettype wire

### tb/sv/tb_laser_scan_to_point_cloud.sv
// ----------------------------------------------------------------------------
// tb_laser_scan_to_point_cloud: self-checking bench for the lidar transform
// Drives beams through the push/full queue port, pops points with a stalling
// receiver, and checks each point against a bit-true CORDIC and affine model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// Point beat as seen on the result ports
typedef struct packed {
  logic                   valid;
  logic signed [30:0]     x;
  logic signed [30:0]     y;
  logic signed [30:0]     z;
  logic                   eos;
} point_t;

class point_scoreboard;
  logic [19:0] min_r, max_r, err_lim;
  logic [31:0] start_a, step_a, offset_a;
  logic [63:0] rows[3];
  point_t      pending[$];
  int          errors;

  function void reset_state();
    min_r = '0; max_r = '0; err_lim = 20'd66;
    start_a = '0; step_a = '0; offset_a = '0;
    rows[0] = 64'h4000_0000_0000_0000;
    rows[1] = 64'h0000_1000_0000_0000;
    rows[2] = '0;
    errors = 0;
  endfunction

  function void write_reg(lstpc_pkg::cfg_reg_e idx, logic [63:0] d);
    case (idx)
      lstpc_pkg::RegMinRange: min_r = d[19:0];
      lstpc_pkg::RegMaxRange: max_r = d[19:0];
      lstpc_pkg::RegErrLimit: err_lim = d[19:0];
      lstpc_pkg::RegStart:    start_a = d[31:0];
      lstpc_pkg::RegStep:     step_a = d[31:0];
      lstpc_pkg::RegRowX:     rows[0] = d;
      lstpc_pkg::RegRowY:     rows[1] = d;
      default:                rows[2] = d;
    endcase
  endfunction

  // One row: Q2.16 coefficients on Q.16 mm, translation in mm, out quarter mm
  function logic signed [30:0] transform_row(logic [63:0] row,
                                             longint px, longint py);
    longint c0, c1, t, acc, q;
    c0 = longint'($signed(row[63:46]));
    c1 = longint'($signed(row[45:28]));
    t = longint'($signed(row[27:0]));
    acc = c0 * px + c1 * py + t * 64'sd4294967296;
    q = (acc + 64'sd536870912) >>> 30;
    if (q > 64'sd1073741823) q = 64'sd1073741823;
    if (q < -64'sd1073741824) q = -64'sd1073741824;
    return q[30:0];
  endfunction

  function void note_beam(logic [19:0] r, logic last);
    point_t p;
    logic [31:0] a, ap;
    logic [1:0] quad;
    longint x, y, z, dx, dy, c, s;
    longint at[16];
    at = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
           10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
           83443, 41722, 20861};
    p = '0;
    p.eos = last;
    a = start_a + offset_a;
    p.valid = (r >= min_r) && (r <= max_r) && (r >= err_lim);
    if (p.valid) begin
      ap = a + 32'h2000_0000;
      quad = ap[31:30];
      z = longint'({2'b0, ap[29:0]}) - 64'sd536870912;
      x = (longint'(r) * 64'sd652032874) >>> 14;
      y = 0;
      for (int i = 0; i < 16; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= at[i];
        end else begin
          x += dx; y -= dy; z += at[i];
        end
      end
      case (quad)
        2'd0: begin c = x; s = y; end
        2'd1: begin c = -y; s = x; end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
      p.x = transform_row(rows[0], -s, c);
      p.y = transform_row(rows[1], -s, c);
      p.z = transform_row(rows[2], -s, c);
    end
    offset_a = last ? 32'd0 : offset_a + step_a;
    pending = {pending, p};
  endfunction

  function void check_point(point_t got);
    point_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected point %p", $time, got);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (got.valid !== e.valid) begin
      $display("%0t: point_valid exp %0d got %0d", $time, e.valid, got.valid);
      errors++;
    end
    if (got.x !== e.x) begin
      $display("%0t: x exp %0d got %0d", $time, e.x, got.x);
      errors++;
    end
    if (got.y !== e.y) begin
      $display("%0t: y exp %0d got %0d", $time, e.y, got.y);
      errors++;
    end
    if (got.z !== e.z) begin
      $display("%0t: z exp %0d got %0d", $time, e.z, got.z);
      errors++;
    end
    if (got.eos !== e.eos) begin
      $display("%0t: end_of_scan exp %0d got %0d", $time, e.eos, got.eos);
      errors++;
    end
  endfunction
endclass

module tb_laser_scan_to_point_cloud;
  import lstpc_pkg::*;

  localparam int CycleLimit = 2_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [RangeW-1:0] range_mm_i = '0;
  logic last_beam_i = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic point_valid_o, end_of_scan_o;
  logic signed [CoordW-1:0] x_quarter_mm_o, y_quarter_mm_o, z_quarter_mm_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  point_scoreboard points;
  int cycles = 0;
  int stall_mode = 0;

  laser_scan_to_point_cloud uut (
    .clk_i, .rst_ni, .push, .full, .range_mm_i, .last_beam_i, .empty, .pop,
    .point_valid_o, .x_quarter_mm_o, .y_quarter_mm_o, .z_quarter_mm_o,
    .end_of_scan_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("** laser_scan_to_point_cloud: FAILED **");
      $finish;
    end
  end

  // Receiver: stalls on a pattern that changes with stall_mode
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty)
        points.check_point({point_valid_o, x_quarter_mm_o, y_quarter_mm_o,
                            z_quarter_mm_o, end_of_scan_o});
      case (stall_mode)
        0: pop <= 1'b1;
        1: pop <= ($urandom_range(0, 3) != 0);
        2: pop <= ($urandom_range(0, 7) == 0);
        default: pop <= cycles[4];
      endcase
    end
  end

  // Leaves cfg_valid_i high; the next task drops it
  task automatic write_cfg(cfg_reg_e idx, logic [63:0] d);
    push <= 1'b0;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    points.write_reg(idx, d);
  endtask

  // Leaves push high so beats can follow back to back
  task automatic send_beam(logic [19:0] r, logic last);
    cfg_valid_i <= 1'b0;
    push <= 1'b1;
    range_mm_i <= r;
    last_beam_i <= last;
    do @(posedge clk_i); while (full);
    points.note_beam(r, last);
  endtask

  // Wait for all points out, then let the back part settle
  task automatic drain();
    push <= 1'b0;
    cfg_valid_i <= 1'b0;
    while (points.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic random_row(cfg_reg_e idx);
    logic [63:0] d;
    case ($urandom_range(0, 3))
      0: d = {$urandom, $urandom};
      1: d = {18'h10000, 18'h0, 2'b00, 26'($urandom)};
      2: d = {18'($urandom_range(0, 131071)), 18'h3ffff ^ 18'($urandom),
              28'h8000000 | 28'($urandom)};
      default: d = {18'h1ffff, 18'h20000, 28'h7ffffff};
    endcase
    write_cfg(idx, d);
  endtask

  task automatic random_beams(int n);
    logic [19:0] r;
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && n > 0; i++, n--) begin
        case ($urandom_range(0, 9))
          0: r = 20'($urandom_range(0, 80));
          1: r = 20'hfffff - 20'($urandom_range(0, 3));
          2: r = 20'($urandom);
          default: r = 20'($urandom_range(60, 40000));
        endcase
        send_beam(r, $urandom_range(0, 15) == 0);
      end
      if ($urandom_range(0, 2) != 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    points = new();
    points.reset_state();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset setting (max 0 -> nothing valid), then full open window
    send_beam(20'd0, 1'b0);
    send_beam(20'd100, 1'b1);
    drain();
    write_cfg(RegMaxRange, 64'hffff_ffff_fff0_0000 | 64'hfffff);
    write_cfg(RegMinRange, 64'd0);
    write_cfg(RegErrLimit, 64'd66);
    write_cfg(RegStep, 64'h4000_0000);
    send_beam(20'd65, 1'b0);
    send_beam(20'd66, 1'b0);
    send_beam(20'd1000, 1'b0);
    send_beam(20'd1000, 1'b0);
    send_beam(20'd1000, 1'b1);
    send_beam(20'hfffff, 1'b0);
    send_beam(20'd12345, 1'b0);
    send_beam(20'd1, 1'b1);
    drain();
    // Saturation: huge gains and translation
    write_cfg(RegRowX, {18'h1ffff, 18'h1ffff, 28'h7ffffff});
    write_cfg(RegRowY, {18'h20000, 18'h20000, 28'h8000000});
    write_cfg(RegRowZ, {18'h10000, 18'h30000, 28'h0000001});
    write_cfg(RegStart, 64'hffff_ffff_e000_0000);
    write_cfg(RegStep, 64'h2000_0000);
    for (int i = 0; i < 8; i++) send_beam(20'hfffff, i == 7);
    // Minimum above maximum
    drain();
    write_cfg(RegMinRange, 64'd5000);
    write_cfg(RegMaxRange, 64'd4000);
    send_beam(20'd4500, 1'b0);
    send_beam(20'd5000, 1'b1);
    drain();

    // Random phases over several settings
    for (int ph = 0; ph < 12; ph++) begin
      stall_mode = ph % 4;
      write_cfg(RegMinRange, ph == 0 ? 64'd0 : 64'($urandom_range(0, 3000)));
      write_cfg(RegMaxRange, ph == 1 ? 64'hfffff : 64'($urandom_range(20000, 1048575)));
      write_cfg(RegErrLimit, ph == 2 ? 64'hfffff : 64'($urandom_range(0, 100)));
      write_cfg(RegStart, ph == 3 ? 64'hffffffff : 64'($urandom));
      write_cfg(RegStep, ph == 4 ? 64'hffffffff : 64'($urandom));
      random_row(RegRowX);
      random_row(RegRowY);
      random_row(RegRowZ);
      random_beams(152);
      drain();
    end

    if (points.errors == 0 && points.pending.size() == 0)
      $display("** laser_scan_to_point_cloud: PASSED **");
    else
      $display("** laser_scan_to_point_cloud: FAILED **");
    $finish;
  end
endmodule

`default_nettype wire
